// ===== rtl/core/ktc_pkg.sv =====
package ktc_pkg;

    // defaults for the top level parameters
    localparam int MAX_TOKEN_LEN_DEF = 32;
    localparam int VALUE_BITS_DEF    = 32;

    // fixed field widths
    localparam int CHAR_W    = 8;
    localparam int CLS_W     = 6;
    localparam int LEN_W     = 6;
    localparam int CONST_W   = 32;
    localparam int PREFIX_N  = 5;
    localparam int PREFIX_W  = PREFIX_N * CHAR_W;

    // queue between front and back
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // class codes
    localparam logic [CLS_W-1:0] CLASS_UNKNOWN = 6'd0;
    localparam logic [CLS_W-1:0] CLASS_ASM     = 6'd33;
    localparam logic [CLS_W-1:0] CLASS_CONST   = 6'd34;
    localparam logic [CLS_W-1:0] CLASS_LABEL   = 6'd35;

    // character codes
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;

    // keyword table, text left aligned with zero padding, first char in the top byte
    localparam int NUM_KW = 32;
    localparam logic [PREFIX_W-1:0] KW_TEXT [NUM_KW] = '{
        {"PSH", 16'h0}, {"POP", 16'h0}, {"ADD", 16'h0}, {"SUB", 16'h0},
        {"RSH", 16'h0}, {"LSH", 16'h0}, {"JMP", 16'h0}, {"JNZ", 16'h0},
        {"JCC", 16'h0}, {"JCS", 16'h0}, {"JZ", 24'h0},  {"JSR", 16'h0},
        {"RTS", 16'h0}, {"HLT", 16'h0}, {"DUP", 16'h0}, {"SWP", 16'h0},
        {"INC", 16'h0}, {"DEC", 16'h0}, {"WRD", 16'h0}, {"WRD_W"},
        {"RDD", 16'h0}, {"AND", 16'h0}, {"OR", 24'h0},  {"XOR", 16'h0},
        {"GT", 24'h0},  {"LT", 24'h0},  {"EQ", 24'h0},  {"GE", 24'h0},
        {"LE", 24'h0},  {"ROT", 16'h0}, {"OVR", 16'h0}, {"@DEF", 8'h0}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4
    };
    localparam logic [PREFIX_W-1:0] ASM_TEXT = {"ASM", 16'h0};
    localparam logic [LEN_W-1:0]    ASM_LEN  = 6'd3;

    // token summary word passed from front to back
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic                too_long;
        logic [PREFIX_W-1:0] prefix;
        logic                is_dec;
        logic                is_hex;
        logic [CONST_W-1:0]  value;
        logic                sat;
        logic                colon_end;
    } t_tok;

    // keyword match, 0 when none
    function automatic logic [CLS_W-1:0] kw_lookup(input logic [PREFIX_W-1:0] text,
                                                   input logic [LEN_W-1:0] len);
        logic [CLS_W-1:0] cls;
        cls = CLASS_UNKNOWN;
        for (int k = 0; k < NUM_KW; k++) begin
            if (cls == CLASS_UNKNOWN && len == LEN_W'(KW_LEN[k]) && text == KW_TEXT[k]) begin
                cls = CLS_W'(k + 1);
            end
        end
        return cls;
    endfunction

endpackage

// ===== rtl/core/ktc_front.sv =====
module ktc_front
    import ktc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_q_full,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_last_char,
    output logic              o_q_push,
    output t_tok              o_tok
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 2);
    localparam int VB    = VALUE_BITS;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CHAR_W-1:0] r_pre [PREFIX_N];
    logic [CHAR_W-1:0] n_pre [PREFIX_N];
    logic              r_digits, n_digits;
    logic              r_hexv, n_hexv;
    logic [VB-1:0]     r_dec, n_dec;
    logic [VB-1:0]     r_hex, n_hex;
    logic              r_dec_ovf, n_dec_ovf;
    logic              r_hex_ovf, n_hex_ovf;

    logic              accept;
    logic              is_dig;
    logic              is_hex_dig;
    logic [3:0]        dig;
    logic [3:0]        hdig;
    logic [VB+3:0]     dec_wide;
    logic              tok_long;

    // per character flag and accumulator update
    always_comb begin
        accept     = i_push && !i_q_full;
        is_dig     = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
        is_hex_dig = is_dig || ((i_character >= CH_UPPER_A) && (i_character <= CH_UPPER_F));
        dig        = 4'(i_character - CH_ZERO);
        hdig       = is_dig ? dig : 4'(i_character - CH_UPPER_A + 8'd10);
        dec_wide   = ({4'b0, r_dec} << 3) + ({4'b0, r_dec} << 1) + (VB + 4)'(dig);

        n_cnt     = r_cnt;
        n_digits  = r_digits;
        n_hexv    = r_hexv;
        n_dec     = r_dec;
        n_hex     = r_hex;
        n_dec_ovf = r_dec_ovf;
        n_hex_ovf = r_hex_ovf;
        for (int i = 0; i < PREFIX_N; i++) begin
            n_pre[i] = r_pre[i];
            if (r_cnt == CNT_W'(i)) begin
                n_pre[i] = i_character;
            end
        end

        if (r_cnt <= CNT_W'(MAX_TOKEN_LEN)) begin
            n_cnt = r_cnt + 1'b1;
        end

        // decimal value
        if (is_dig) begin
            if (|dec_wide[VB+3:VB]) begin
                n_dec     = '1;
                n_dec_ovf = 1'b1;
            end else begin
                n_dec = dec_wide[VB-1:0];
            end
        end else begin
            n_digits = 1'b0;
        end

        // dollar hex value
        if (r_cnt == '0) begin
            if (i_character != CH_DOLLAR) begin
                n_hexv = 1'b0;
            end
        end else if (!is_hex_dig) begin
            n_hexv = 1'b0;
        end else if (|r_hex[VB-1:VB-4]) begin
            n_hex     = '1;
            n_hex_ovf = 1'b1;
        end else begin
            n_hex = {r_hex[VB-5:0], hdig};
        end
    end

    // summary word built from the updated state
    always_comb begin
        tok_long         = n_cnt > CNT_W'(MAX_TOKEN_LEN);
        o_tok.too_long   = tok_long;
        o_tok.len        = tok_long ? LEN_W'(MAX_TOKEN_LEN) : LEN_W'(n_cnt);
        for (int i = 0; i < PREFIX_N; i++) begin
            o_tok.prefix[PREFIX_W-1-CHAR_W*i -: CHAR_W] = n_pre[i];
        end
        o_tok.is_dec     = n_digits;
        o_tok.is_hex     = n_hexv && (n_cnt >= CNT_W'(2));
        o_tok.value      = n_digits ? CONST_W'(n_dec) : CONST_W'(n_hex);
        o_tok.sat        = n_digits ? n_dec_ovf : n_hex_ovf;
        o_tok.colon_end  = i_character == CH_COLON;
        o_q_push         = accept && i_last_char;
    end

    // token state, cleared after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_char)) begin
            r_cnt     <= '0;
            r_digits  <= 1'b1;
            r_hexv    <= 1'b1;
            r_dec     <= '0;
            r_hex     <= '0;
            r_dec_ovf <= 1'b0;
            r_hex_ovf <= 1'b0;
            for (int i = 0; i < PREFIX_N; i++) begin
                r_pre[i] <= '0;
            end
        end else if (accept) begin
            r_cnt     <= n_cnt;
            r_digits  <= n_digits;
            r_hexv    <= n_hexv;
            r_dec     <= n_dec;
            r_hex     <= n_hex;
            r_dec_ovf <= n_dec_ovf;
            r_hex_ovf <= n_hex_ovf;
            for (int i = 0; i < PREFIX_N; i++) begin
                r_pre[i] <= n_pre[i];
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_char |=> r_cnt == '0 && r_digits && r_hexv)
        else $error("token state not cleared after final character");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_TOKEN_LEN + 1))
        else $error("character count past its clamp");

endmodule

// ===== rtl/core/ktc_queue.sv =====
module ktc_queue
    import ktc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_tok o_data
);

    t_tok               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    // status and head word
    always_comb begin
        o_full  = r_cnt == Q_CNT_W'(Q_DEPTH);
        o_empty = r_cnt == '0;
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_data  = r_mem[r_rd];
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count past depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != Q_CNT_W'(Q_DEPTH) && r_cnt != '0 |-> r_wr != r_rd)
        else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/core/ktc_back.sv =====
module ktc_back
    import ktc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_tok               i_tok,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [CLS_W-1:0]   o_token_class,
    output logic               o_hex_form,
    output logic [CONST_W-1:0] o_const_value,
    output logic               o_value_saturated,
    output logic               o_too_long,
    output logic [LEN_W-1:0]   o_token_length
);

    logic               r_valid;
    logic [CLS_W-1:0]   r_cls;
    logic               r_hexf;
    logic [CONST_W-1:0] r_val;
    logic               r_sat;
    logic               r_long;
    logic [LEN_W-1:0]   r_len;

    logic               take;
    logic [CLS_W-1:0]   kw_cls;
    logic [CLS_W-1:0]   n_cls;
    logic               n_hexf;
    logic [CONST_W-1:0] n_val;
    logic               n_sat;

    // classification of the head word
    always_comb begin
        take   = !i_q_empty && (!r_valid || i_pop);
        kw_cls = kw_lookup(i_tok.prefix, i_tok.len);
        n_cls  = CLASS_UNKNOWN;
        n_hexf = 1'b0;
        n_val  = '0;
        n_sat  = 1'b0;
        if (!i_tok.too_long) begin
            if (kw_cls != CLASS_UNKNOWN) begin
                n_cls = kw_cls;
            end else if (i_tok.len == ASM_LEN && i_tok.prefix == ASM_TEXT) begin
                n_cls = CLASS_ASM;
            end else if (i_tok.is_dec || i_tok.is_hex) begin
                n_cls  = CLASS_CONST;
                n_hexf = !i_tok.is_dec;
                n_val  = i_tok.value;
                n_sat  = i_tok.sat;
            end else if (i_tok.colon_end) begin
                n_cls = CLASS_LABEL;
            end
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls  <= n_cls;
            r_hexf <= n_hexf;
            r_val  <= n_val;
            r_sat  <= n_sat;
            r_long <= i_tok.too_long;
            r_len  <= i_tok.len;
        end
    end

    // output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_q_pop           = take;
    assign o_empty           = !r_valid;
    assign o_token_class     = r_cls;
    assign o_hex_form        = r_hexf;
    assign o_const_value     = r_val;
    assign o_value_saturated = r_sat;
    assign o_too_long        = r_long;
    assign o_token_length    = r_len;

    a_long_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_long |-> r_cls == CLASS_UNKNOWN && r_val == '0)
        else $error("overlong token given a class");

    a_value_only_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_hexf || r_sat || r_val != '0) |-> r_cls == CLASS_CONST)
        else $error("constant fields set on a non-constant word");

endmodule

// ===== rtl/core/keyword_token_classifier_top.sv =====
// flow: each token's word is queued on its final character, then registered for output
// throughput: one character per cycle; the front stalls only when the four-entry token
//   queue is full, the back loads one token per cycle while its output is empty or popped
// reset: synchronous active-low i_rst_n clears token state, queue and output valid
module keyword_token_classifier_top
    import ktc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CHAR_W-1:0]  i_character,
    input  logic               i_last_char,
    output logic               empty,
    input  logic               pop,
    output logic [CLS_W-1:0]   o_token_class,
    output logic               o_hex_form,
    output logic [CONST_W-1:0] o_const_value,
    output logic               o_value_saturated,
    output logic               o_too_long,
    output logic [LEN_W-1:0]   o_token_length
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_tok q_in;
    t_tok q_out;

    // character front end
    ktc_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .VALUE_BITS    (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_q_full    (q_full),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .o_q_push    (q_push),
        .o_tok       (q_in)
    );

    // token queue
    ktc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // classification back end
    ktc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_tok             (q_out),
        .o_q_pop           (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_token_class     (o_token_class),
        .o_hex_form        (o_hex_form),
        .o_const_value     (o_const_value),
        .o_value_saturated (o_value_saturated),
        .o_too_long        (o_too_long),
        .o_token_length    (o_token_length)
    );

    assign full = q_full;

endmodule

// ===== bench/tb_keyword_token_classifier_top.sv =====
`timescale 1ns / 100ps

module tb_keyword_token_classifier_top;
    import ktc_pkg::*;

    localparam int          MAX_LEN        = MAX_TOKEN_LEN_DEF;
    localparam logic [63:0] VALUE_MAX      = (~64'h0) >> (64 - VALUE_BITS_DEF);
    localparam int unsigned RANDOM_CHARS   = 760;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t token_text_t[$];

    // one classified token as it leaves the block
    typedef struct {
        logic [CLS_W-1:0]   cls;
        logic               hex_form;
        logic [CONST_W-1:0] value;
        logic               saturated;
        logic               too_long;
        logic [LEN_W-1:0]   length;
    } token_word_t;

    // predicts one word per token and compares it with what the block gives
    class token_scoreboard;
        token_word_t pending_words[$];
        int unsigned error_count;
        string       keywords[NUM_KW];

        // running state of the token being assembled
        int unsigned seen;
        char_t       head[PREFIX_N];
        bit          all_digits;
        bit          dollar_hex;
        logic [63:0] dec_val;
        logic [63:0] hex_val;
        bit          dec_clamped;
        bit          hex_clamped;

        function new();
            keywords = '{"PSH", "POP", "ADD", "SUB", "RSH", "LSH", "JMP", "JNZ",
                         "JCC", "JCS", "JZ", "JSR", "RTS", "HLT", "DUP", "SWP",
                         "INC", "DEC", "WRD", "WRD_W", "RDD", "AND", "OR", "XOR",
                         "GT", "LT", "EQ", "GE", "LE", "ROT", "OVR", "@DEF"};
            error_count = 0;
            clear_token();
        endfunction

        function void clear_token();
            seen = 0;
            foreach (head[i]) head[i] = '0;
            all_digits  = 1'b1;
            dollar_hex  = 1'b1;
            dec_val     = '0;
            hex_val     = '0;
            dec_clamped = 1'b0;
            hex_clamped = 1'b0;
        endfunction

        // token of length n equals the text s
        function bit head_is(string s, int unsigned n);
            if (n != s.len()) return 1'b0;
            for (int i = 0; i < s.len(); i++) begin
                if (head[i] != char_t'(s[i])) return 1'b0;
            end
            return 1'b1;
        endfunction

        // uppercase hex digit value, -1 when not a hex digit
        function int nibble_of(char_t c);
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
            if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
            return -1;
        endfunction

        // one accepted character; the last one of a token queues a word
        function void take_char(char_t c, logic last);
            int unsigned pos;
            int          nib;
            logic [63:0] digit;
            token_word_t w;
            pos = seen;
            if (pos < PREFIX_N) head[pos] = c;
            if (seen <= MAX_LEN) seen++;

            // decimal accumulation with clamp
            if (c >= CH_ZERO && c <= CH_NINE) begin
                digit = 64'(c - CH_ZERO);
                if (dec_val > (VALUE_MAX - digit) / 10) begin
                    dec_val = VALUE_MAX;
                    dec_clamped = 1'b1;
                end else begin
                    dec_val = dec_val * 10 + digit;
                end
            end else begin
                all_digits = 1'b0;
            end

            // dollar hex accumulation with clamp
            if (pos == 0) begin
                if (c != CH_DOLLAR) dollar_hex = 1'b0;
            end else begin
                nib = nibble_of(c);
                if (nib < 0) begin
                    dollar_hex = 1'b0;
                end else if (hex_val > ((VALUE_MAX - 64'(nib)) >> 4)) begin
                    hex_val = VALUE_MAX;
                    hex_clamped = 1'b1;
                end else begin
                    hex_val = (hex_val << 4) | 64'(nib);
                end
            end

            if (!last) return;

            w.cls       = CLASS_UNKNOWN;
            w.hex_form  = 1'b0;
            w.value     = '0;
            w.saturated = 1'b0;
            w.too_long  = 1'b0;
            if (seen > MAX_LEN) begin
                w.too_long = 1'b1;
                w.length   = LEN_W'(MAX_LEN);
            end else begin
                w.length = LEN_W'(seen);
                for (int k = 0; k < NUM_KW; k++) begin
                    if (w.cls == CLASS_UNKNOWN && head_is(keywords[k], seen))
                        w.cls = CLS_W'(k + 1);
                end
                if (w.cls == CLASS_UNKNOWN) begin
                    if (head_is("ASM", seen)) begin
                        w.cls = CLASS_ASM;
                    end else if (all_digits) begin
                        w.cls       = CLASS_CONST;
                        w.value     = dec_val[CONST_W-1:0];
                        w.saturated = dec_clamped;
                    end else if (dollar_hex && seen >= 2) begin
                        w.cls       = CLASS_CONST;
                        w.hex_form  = 1'b1;
                        w.value     = hex_val[CONST_W-1:0];
                        w.saturated = hex_clamped;
                    end else if (c == CH_COLON) begin
                        w.cls = CLASS_LABEL;
                    end
                end
            end
            pending_words.push_back(w);
            clear_token();
        endfunction

        // one word taken from the block, against the oldest prediction
        function void check_word(token_word_t got);
            token_word_t want;
            if (pending_words.size() == 0) begin
                $error("word with no token pending: token_class %0d", got.cls);
                error_count++;
                return;
            end
            want = pending_words.pop_front();
            if (got.cls !== want.cls) begin
                $error("token_class: expected %0d, actual %0d", want.cls, got.cls);
                error_count++;
            end
            if (got.hex_form !== want.hex_form) begin
                $error("hex_form: expected %0d, actual %0d", want.hex_form, got.hex_form);
                error_count++;
            end
            if (got.value !== want.value) begin
                $error("const_value: expected %0d, actual %0d", want.value, got.value);
                error_count++;
            end
            if (got.saturated !== want.saturated) begin
                $error("value_saturated: expected %0d, actual %0d",
                       want.saturated, got.saturated);
                error_count++;
            end
            if (got.too_long !== want.too_long) begin
                $error("too_long: expected %0d, actual %0d", want.too_long, got.too_long);
                error_count++;
            end
            if (got.length !== want.length) begin
                $error("token_length: expected %0d, actual %0d", want.length, got.length);
                error_count++;
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic [CHAR_W-1:0]  i_character = '0;
    logic               i_last_char = 1'b0;
    logic               pop         = 1'b0;
    logic               full;
    logic               empty;
    logic [CLS_W-1:0]   o_token_class;
    logic               o_hex_form;
    logic [CONST_W-1:0] o_const_value;
    logic               o_value_saturated;
    logic               o_too_long;
    logic [LEN_W-1:0]   o_token_length;

    token_scoreboard sb;
    int unsigned     cycle_count = 0;
    int unsigned     chars_sent  = 0;
    int unsigned     burst_left  = 0;
    bit              tx_steady   = 1'b0;
    bit              rx_hold_req = 1'b0;

    keyword_token_classifier_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_character       (i_character),
        .i_last_char       (i_last_char),
        .empty             (empty),
        .pop               (pop),
        .o_token_class     (o_token_class),
        .o_hex_form        (o_hex_form),
        .o_const_value     (o_const_value),
        .o_value_saturated (o_value_saturated),
        .o_too_long        (o_too_long),
        .o_token_length    (o_token_length)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // word monitor
    always @(posedge i_clk) begin : word_monitor
        token_word_t got;
        if (pop && !empty) begin
            got.cls       = o_token_class;
            got.hex_form  = o_hex_form;
            got.value     = o_const_value;
            got.saturated = o_value_saturated;
            got.too_long  = o_too_long;
            got.length    = o_token_length;
            sb.check_word(got);
        end
    end

    // receiver: rotating stall patterns, plus a long hold on request
    initial begin : receiver
        int unsigned tick;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            case ((tick / 97) % 4)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ((tick % 7) < 4);
                default: pop <= ($urandom_range(0, 9) < 2);
            endcase
            tick++;
        end
    end

    // one character, after a random gap at the end of a burst when not in steady mode
    task automatic send_char(input char_t c, input logic last);
        int unsigned gap;
        if (!tx_steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left--;
        end
        push        <= 1'b1;
        i_character <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.take_char(c, last);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_token(input token_text_t t);
        foreach (t[i]) send_char(t[i], i == t.size() - 1);
    endtask

    // stop offering and wait for every predicted word
    task automatic settle();
        push <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_words.size() != 0) @(negedge i_clk);
    endtask

    function automatic token_text_t text_of(string s);
        token_text_t t;
        for (int i = 0; i < s.len(); i++) t.push_back(char_t'(s[i]));
        return t;
    endfunction

    function automatic char_t hex_char(int unsigned v);
        return (v < 10) ? char_t'(CH_ZERO + v) : char_t'(CH_UPPER_A + v - 10);
    endfunction

    // random token: mostly well-formed classes, some broken, some noise
    function automatic token_text_t random_token();
        token_text_t t;
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            // keyword, now and then slightly off
            t = text_of(sb.keywords[$urandom_range(0, NUM_KW - 1)]);
            case ($urandom_range(0, 5))
                0: t[$urandom_range(0, t.size() - 1)] = char_t'($urandom_range(0, 255));
                1: t.push_back(char_t'($urandom_range(32, 126)));
                2: void'(t.pop_back());
                default: ;
            endcase
        end else if (pick < 27) begin
            case ($urandom_range(0, 3))
                0: t = text_of("ASMX");
                1: t = text_of("AS");
                2: t = text_of("asm");
                default: t = text_of("ASM");
            endcase
        end else if (pick < 47) begin
            // decimal, some near the clamp point
            if ($urandom_range(0, 3) == 0) begin
                t = text_of("42949672");
                n = $urandom_range(1, 3);
            end else begin
                n = $urandom_range(1, 12);
            end
            repeat (n) t.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 7) == 0)
                t[$urandom_range(0, t.size() - 1)] = char_t'($urandom_range(0, 255));
        end else if (pick < 67) begin
            // dollar hex, lone dollar included
            t.push_back(CH_DOLLAR);
            if ($urandom_range(0, 3) == 0) begin
                repeat (7) t.push_back(hex_char(15));
                n = $urandom_range(1, 2);
            end else begin
                n = $urandom_range(0, 10);
            end
            repeat (n) t.push_back(hex_char($urandom_range(0, 15)));
            if (t.size() > 1 && $urandom_range(0, 5) == 0)
                t[$urandom_range(1, t.size() - 1)] = ($urandom_range(0, 1) == 1) ?
                    char_t'($urandom_range(8'h61, 8'h66)) : char_t'($urandom_range(0, 255));
        end else if (pick < 80) begin
            // label
            n = $urandom_range(0, 6);
            repeat (n) t.push_back(char_t'($urandom_range(33, 126)));
            t.push_back(CH_COLON);
        end else if (pick < 97) begin
            // noise bytes
            n = $urandom_range(1, 8);
            repeat (n) t.push_back(char_t'($urandom_range(0, 255)));
        end else begin
            // around the length limit
            n = $urandom_range(MAX_LEN - 2, MAX_LEN + 8);
            if ($urandom_range(0, 1) == 1)
                repeat (n) t.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
            else
                repeat (n) t.push_back(char_t'($urandom_range(0, 255)));
        end
        return t;
    endfunction

    // stimulus and end of run
    initial begin : stimulus
        string       directed [14];
        token_text_t t;
        int unsigned tokens_sent;
        directed = '{"PSH", "JZ", "WRD_W", "@DEF", "ASM", "0", "4294967295",
                     "4294967296", "$FFFFFFFF", "$100000000", "$", "$1a", "LOOP:", ":"};
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed tokens
        foreach (directed[i]) send_token(text_of(directed[i]));
        t = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        send_token(t);
        t = text_of("42");
        while (t.size() < MAX_LEN) t.push_front(CH_ZERO);
        send_token(t);
        t.push_back(CH_ZERO);
        send_token(t);
        settle();

        // random tokens
        chars_sent  = 0;
        tokens_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            if (tokens_sent % 20 == 0) tx_steady = ($urandom_range(0, 3) == 0);
            if (tokens_sent == 60) begin
                // back up the block while the receiver holds off
                rx_hold_req = 1'b1;
                tx_steady   = 1'b1;
                repeat (40) send_token(text_of(sb.keywords[$urandom_range(0, NUM_KW - 1)]));
                tx_steady   = 1'b0;
            end
            if (tokens_sent == 90) settle();
            send_token(random_token());
            tokens_sent++;
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
